// File: sv/spiral_sample_point_generator_top_macros.svh
// Assertion macros shared by the spiral sample point generator RTL.
`ifndef SPIRAL_SAMPLE_POINT_GENERATOR_TOP_MACROS_SVH
`define SPIRAL_SAMPLE_POINT_GENERATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define SSPG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spiral point generator: assertion failed");
// Next-cycle implication, disabled while reset is high.
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spiral point generator: assertion failed");
`else
`define SSPG_ASSERT_SAME(label, clk, rst, ante, cons)
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/sspg_pkg.sv
// Constants and the quarter-wave sine function of the spiral sample point generator.
package sspg_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int MAX_SIDE     = 4096;

  // Quarter-wave polynomial coefficients, Q14.
  localparam int unsigned SIN_A = 25736;
  localparam int unsigned SIN_B = 10512;
  localparam int unsigned SIN_C = 1160;

  localparam int ANGLE_BITS = 16;
  localparam int PROD_FRAC  = 26;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_RADIUS_STEP  = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd1;
  localparam logic [2:0] REG_PHASE        = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [2:0] REG_SAMPLE_COUNT = 3'd5;

  // Reset values of the registers.
  localparam logic [19:0] RST_RADIUS_STEP  = 20'd4096;
  localparam logic [15:0] RST_ANGLE_STEP   = 16'd1024;
  localparam logic [15:0] RST_PHASE        = 16'd0;
  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [15:0] RST_SAMPLE_COUNT = 16'd256;

  // Sine of a first-quadrant angle z (Q14, 0 to 16384), Q1.14, every product floored.
  // Called with constant arguments only, so it folds into a table.
  function automatic logic [14:0] quarter_sine(input int unsigned z);
    int unsigned z2;
    int unsigned t;
    int unsigned t2;
    int unsigned s;
    z2 = (z * z) >> 14;
    t  = SIN_B - ((z2 * SIN_C) >> 14);
    t2 = SIN_A - ((z2 * t) >> 14);
    s  = (z * t2) >> 14;
    return s[14:0];
  endfunction

endpackage

// File: sv/spiral_sample_point_generator_top.sv
// Archimedean spiral sample point generator: state update, sine lookup, multiply, place.
// Throughput: one tick per cycle while the point channel does not stall; the accumulators
// update in the accept cycle, the rest is a five-register pipeline (input, sine/cosine
// table, multiply, centre add, saturate).
// Reset clears the accumulators and pipeline valids and loads the register defaults.
`include "spiral_sample_point_generator_top_macros.svh"

module spiral_sample_point_generator_top #(
  parameter int SINE_ENTRIES = sspg_pkg::SINE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // tick channel
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic               restart,
  // point channel
  output logic               point_valid,
  input  logic               point_stall,
  output logic signed [13:0] coord_x,
  output logic signed [13:0] coord_y,
  output logic               inside_image,
  output logic [15:0]        sample_index,
  output logic               last_sample
);

  localparam int SINE_BITS = $clog2(SINE_ENTRIES);
  localparam int QUARTER   = SINE_ENTRIES / 4;
  localparam int QBITS     = SINE_BITS - 1;
  localparam int ZSHIFT    = sspg_pkg::ANGLE_BITS - SINE_BITS;
  localparam int FRAC      = sspg_pkg::PROD_FRAC;
  localparam logic [13:0] SIDE_LIMIT = 14'(sspg_pkg::MAX_SIDE - 1);

  // Configuration registers.
  logic [19:0] radius_step;
  logic [15:0] angle_step;
  logic [15:0] phase;
  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [15:0] sample_count;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_step  <= sspg_pkg::RST_RADIUS_STEP;
      angle_step   <= sspg_pkg::RST_ANGLE_STEP;
      phase        <= sspg_pkg::RST_PHASE;
      image_width  <= sspg_pkg::RST_IMAGE_WIDTH;
      image_height <= sspg_pkg::RST_IMAGE_HEIGHT;
      sample_count <= sspg_pkg::RST_SAMPLE_COUNT;
    end else if (cfg_write) begin
      case (paddr[4:2])
        sspg_pkg::REG_RADIUS_STEP:  radius_step  <= pwdata[19:0];
        sspg_pkg::REG_ANGLE_STEP:   angle_step   <= pwdata[15:0];
        sspg_pkg::REG_PHASE:        phase        <= pwdata[15:0];
        sspg_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[11:0];
        sspg_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[11:0];
        sspg_pkg::REG_SAMPLE_COUNT: sample_count <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      sspg_pkg::REG_RADIUS_STEP:  prdata = {12'd0, radius_step};
      sspg_pkg::REG_ANGLE_STEP:   prdata = {16'd0, angle_step};
      sspg_pkg::REG_PHASE:        prdata = {16'd0, phase};
      sspg_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, image_width};
      sspg_pkg::REG_IMAGE_HEIGHT: prdata = {20'd0, image_height};
      sspg_pkg::REG_SAMPLE_COUNT: prdata = {16'd0, sample_count};
      default:                    prdata = 32'd0;
    endcase
  end

  // Image sides clamped to the largest supported side, and the centre point.
  logic [11:0] side_w;
  logic [11:0] side_h;
  logic [10:0] centre_x;
  logic [10:0] centre_y;

  assign side_w   = ({2'b00, image_width} > SIDE_LIMIT) ? SIDE_LIMIT[11:0] : image_width;
  assign side_h   = ({2'b00, image_height} > SIDE_LIMIT) ? SIDE_LIMIT[11:0] : image_height;
  assign centre_x = side_w[11:1];
  assign centre_y = side_h[11:1];

  // Pipeline flow control: a stage loads when it is empty or its content moves on.
  logic p1_valid, p2_valid, p3_valid, p4_valid;
  logic out_ready, r4, r3, r2, r1;
  logic accept;

  assign out_ready  = !point_valid || !point_stall;
  assign r4         = !p4_valid || out_ready;
  assign r3         = !p3_valid || r4;
  assign r2         = !p2_valid || r3;
  assign r1         = !p1_valid || r2;
  assign tick_stall = !r1;
  assign accept     = tick_valid && r1;

  // Spiral state and its update in the accept cycle.
  logic [31:0] radius_accum;
  logic [15:0] angle_accum;
  logic [15:0] index_counter;
  logic [31:0] cur_radius;
  logic [15:0] cur_angle;
  logic [15:0] cur_index;
  logic [16:0] index_inc;
  logic        last_now;
  logic [32:0] radius_sum;
  logic [31:0] radius_next;

  assign cur_radius  = restart ? 32'd0 : radius_accum;
  assign cur_angle   = restart ? 16'd0 : angle_accum;
  assign cur_index   = restart ? 16'd0 : index_counter;
  assign index_inc   = {1'b0, cur_index} + 17'd1;
  assign last_now    = index_inc >= {1'b0, sample_count};
  assign radius_sum  = {1'b0, cur_radius} + {13'd0, radius_step};
  assign radius_next = radius_sum[32] ? 32'hFFFF_FFFF : radius_sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_accum  <= '0;
      angle_accum   <= '0;
      index_counter <= '0;
    end else if (accept) begin
      if (last_now) begin
        radius_accum  <= '0;
        angle_accum   <= '0;
        index_counter <= '0;
      end else begin
        radius_accum  <= radius_next;
        angle_accum   <= cur_angle + angle_step;
        index_counter <= index_inc[15:0];
      end
    end
  end

  // Stage 1: the sample as taken from the state.
  logic [31:0] p1_radius;
  logic [15:0] p1_angle;
  logic [15:0] p1_index;
  logic        p1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (r1) begin
      p1_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_radius <= cur_radius;
      p1_angle  <= cur_angle + phase;
      p1_index  <= cur_index;
      p1_last   <= last_now;
    end
  end

  // Quarter-wave sine table, entries 0 to QUARTER inclusive, built from constants.
  logic [14:0] qtab [QUARTER + 1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
    assign qtab[k] = sspg_pkg::quarter_sine(k << ZSHIFT);
  end

  // Full-wave sine at a table index: mirror over odd quadrants, negate over the lower half.
  function automatic logic signed [15:0] trig_lookup(input logic [SINE_BITS-1:0] t);
    logic [1:0]       quad;
    logic [QBITS-1:0] off;
    logic [QBITS-1:0] zi;
    logic [15:0]      mag;
    quad = t[SINE_BITS-1 -: 2];
    off  = {1'b0, t[SINE_BITS-3:0]};
    zi   = quad[0] ? (QBITS'(QUARTER) - off) : off;
    mag  = {1'b0, qtab[zi]};
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  logic [SINE_BITS-1:0] sin_idx;
  logic [SINE_BITS-1:0] cos_idx;

  assign sin_idx = p1_angle[15 -: SINE_BITS];
  // A quarter turn ahead is exactly QUARTER table steps.
  assign cos_idx = sin_idx + SINE_BITS'(QUARTER);

  // Stage 2: sine and cosine.
  logic [31:0]        p2_radius;
  logic signed [15:0] p2_sin;
  logic signed [15:0] p2_cos;
  logic [15:0]        p2_index;
  logic               p2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (r2) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && p1_valid) begin
      p2_radius <= p1_radius;
      p2_sin    <= trig_lookup(sin_idx);
      p2_cos    <= trig_lookup(cos_idx);
      p2_index  <= p1_index;
      p2_last   <= p1_last;
    end
  end

  // Stage 3: radius times trig, 26 fraction bits.
  logic signed [48:0] p3_prod_x;
  logic signed [48:0] p3_prod_y;
  logic [15:0]        p3_index;
  logic               p3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (r3) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && p2_valid) begin
      p3_prod_x <= 49'($signed({1'b0, p2_radius})) * 49'(p2_cos);
      p3_prod_y <= 49'($signed({1'b0, p2_radius})) * 49'(p2_sin);
      p3_index  <= p2_index;
      p3_last   <= p2_last;
    end
  end

  // Stage 4: centre added at the same scale.
  logic signed [49:0] p4_tot_x;
  logic signed [49:0] p4_tot_y;
  logic [15:0]        p4_index;
  logic               p4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (r4) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && p3_valid) begin
      p4_tot_x <= $signed({p3_prod_x[48], p3_prod_x})
                + $signed({13'd0, centre_x, 26'd0});
      p4_tot_y <= $signed({p3_prod_y[48], p3_prod_y})
                + $signed({13'd0, centre_y, 26'd0});
      p4_index <= p3_index;
      p4_last  <= p3_last;
    end
  end

  // Truncation toward zero: floor, plus one for a negative value with a fraction.
  logic signed [23:0] q_x;
  logic signed [23:0] q_y;
  logic signed [13:0] sat_x;
  logic signed [13:0] sat_y;
  logic               in_x;
  logic               in_y;

  assign q_x = $signed(p4_tot_x[49:FRAC])
             + $signed({23'd0, p4_tot_x[49] && (|p4_tot_x[FRAC-1:0])});
  assign q_y = $signed(p4_tot_y[49:FRAC])
             + $signed({23'd0, p4_tot_y[49] && (|p4_tot_y[FRAC-1:0])});

  always_comb begin
    if (q_x > 24'sd8191) begin
      sat_x = 14'sd8191;
    end else if (q_x < -24'sd8192) begin
      sat_x = -14'sd8192;
    end else begin
      sat_x = q_x[13:0];
    end
    if (q_y > 24'sd8191) begin
      sat_y = 14'sd8191;
    end else if (q_y < -24'sd8192) begin
      sat_y = -14'sd8192;
    end else begin
      sat_y = q_y[13:0];
    end
  end

  assign in_x = !sat_x[13] && (sat_x[12:0] < {1'b0, side_w});
  assign in_y = !sat_y[13] && (sat_y[12:0] < {1'b0, side_h});

  // Stage 5: result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (out_ready) begin
      point_valid <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && p4_valid) begin
      coord_x      <= sat_x;
      coord_y      <= sat_y;
      inside_image <= in_x && in_y;
      sample_index <= p4_index;
      last_sample  <= p4_last;
    end
  end

  `SSPG_ASSERT_NEXT(a_restart_index, clk, rst, accept && restart, p1_index == 16'd0)
  `SSPG_ASSERT_NEXT(a_wrap_clears, clk, rst, accept && last_now,
                    index_counter == 16'd0 && angle_accum == 16'd0 && radius_accum == 32'd0)
  `SSPG_ASSERT_NEXT(a_stage4_hold, clk, rst, p4_valid && !out_ready,
                    p4_valid && $stable(p4_tot_x))
  `SSPG_ASSERT_SAME(a_inside_nonneg, clk, rst, point_valid && inside_image,
                    !coord_x[13] && !coord_y[13])

endmodule

// File: bench/spiral_sample_point_generator_top_tb.sv
// Self-checking testbench for the spiral sample point generator, with an in-bench predictor.
module spiral_sample_point_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 10;
  // Addresses past the register list; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic               in_image;
    logic [15:0]        index;
    logic               last;
  } spiral_point_t;

  class spiral_point_predictor;
    bit [19:0] radius_step;
    bit [15:0] angle_step;
    bit [15:0] phase;
    bit [11:0] width;
    bit [11:0] height;
    bit [15:0] count;
    bit [31:0] radius;
    bit [15:0] angle;
    bit [15:0] index;
    spiral_point_t expected_points[$];
    int mismatches;
    int ticks;
    int points;

    function new();
      radius_step = sspg_pkg::RST_RADIUS_STEP;
      angle_step  = sspg_pkg::RST_ANGLE_STEP;
      phase       = sspg_pkg::RST_PHASE;
      width       = sspg_pkg::RST_IMAGE_WIDTH;
      height      = sspg_pkg::RST_IMAGE_HEIGHT;
      count       = sspg_pkg::RST_SAMPLE_COUNT;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] value);
      case (idx)
        sspg_pkg::REG_RADIUS_STEP:  radius_step = value[19:0];
        sspg_pkg::REG_ANGLE_STEP:   angle_step  = value[15:0];
        sspg_pkg::REG_PHASE:        phase       = value[15:0];
        sspg_pkg::REG_IMAGE_WIDTH:  width       = value[11:0];
        sspg_pkg::REG_IMAGE_HEIGHT: height      = value[11:0];
        sspg_pkg::REG_SAMPLE_COUNT: count       = value[15:0];
        default: ;
      endcase
    endfunction

    // The angle is first snapped down to a table entry, then the quarter-wave
    // polynomial is folded over the four quadrants.
    static function int sine_at(bit [15:0] ang);
      longint unsigned slot;
      longint unsigned snapped;
      bit [15:0] a;
      int unsigned f, z, z2, t, t2, s;
      slot    = (longint'(ang) * sspg_pkg::SINE_ENTRIES) >> 16;
      snapped = (slot * 65536) / sspg_pkg::SINE_ENTRIES;
      a  = snapped[15:0];
      f  = a[13:0];
      z  = a[14] ? 16384 - f : f;
      z2 = (z * z) >> 14;
      t  = sspg_pkg::SIN_B - ((z2 * sspg_pkg::SIN_C) >> 14);
      t2 = sspg_pkg::SIN_A - ((z2 * t) >> 14);
      s  = (z * t2) >> 14;
      return a[15] ? -int'(s) : int'(s);
    endfunction

    static function int place(int unsigned centre, bit [31:0] r, int trig);
      longint total, whole;
      total = (longint'(centre) <<< 26) + longint'({32'b0, r}) * longint'(trig);
      if (total >= 0) whole = total >>> 26;
      else whole = -((-total) >>> 26);
      if (whole > 8191) whole = 8191;
      if (whole < -8192) whole = -8192;
      return int'(whole);
    endfunction

    function void note_tick(bit restart);
      int unsigned w, h;
      bit [15:0] ang, cos_ang;
      int x, y;
      bit [32:0] grown;
      spiral_point_t p;
      w = (width > sspg_pkg::MAX_SIDE - 1) ? sspg_pkg::MAX_SIDE - 1 : width;
      h = (height > sspg_pkg::MAX_SIDE - 1) ? sspg_pkg::MAX_SIDE - 1 : height;
      if (restart) begin
        radius = 0;
        angle  = 0;
        index  = 0;
      end
      ang     = angle + phase;
      cos_ang = ang + 16'h4000;
      x = place(w / 2, radius, sine_at(cos_ang));
      y = place(h / 2, radius, sine_at(ang));
      p.x        = x[13:0];
      p.y        = y[13:0];
      p.in_image = x >= 0 && y >= 0 && x < int'(w) && y < int'(h);
      p.index    = index;
      p.last     = int'(index) + 1 >= int'(count);
      expected_points.push_back(p);
      ticks++;
      if (p.last) begin
        radius = 0;
        angle  = 0;
        index  = 0;
      end else begin
        grown  = radius + radius_step;
        radius = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
        angle  = angle + angle_step;
        index  = index + 1;
      end
    endfunction

    function void check_point(spiral_point_t got);
      spiral_point_t want;
      if (expected_points.size() == 0) begin
        $error("point beat with nothing expected: x=%0d y=%0d index=%0d",
               got.x, got.y, got.index);
        mismatches++;
        return;
      end
      want = expected_points.pop_front();
      points++;
      if (got.x !== want.x) begin
        $error("coord_x: expected %0d, got %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("coord_y: expected %0d, got %0d", want.y, got.y);
        mismatches++;
      end
      if (got.in_image !== want.in_image) begin
        $error("inside_image: expected %0b, got %0b", want.in_image, got.in_image);
        mismatches++;
      end
      if (got.index !== want.index) begin
        $error("sample_index: expected %0d, got %0d", want.index, got.index);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_sample: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               tick_valid;
  logic               tick_stall;
  logic               restart;
  logic               point_valid;
  logic               point_stall;
  logic signed [13:0] coord_x;
  logic signed [13:0] coord_y;
  logic               inside_image;
  logic [15:0]        sample_index;
  logic               last_sample;

  spiral_point_predictor tracker;
  spiral_point_t seen_point;
  int cycle_count;
  int stall_mode;
  int hold_requests;
  int holds_served;
  int hold_left;
  int pattern_phase;
  int settings_tried;

  spiral_sample_point_generator_top dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Point receiver: checks each accepted beat and picks its next stall.
  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall) begin
      seen_point.x        = coord_x;
      seen_point.y        = coord_y;
      seen_point.in_image = inside_image;
      seen_point.index    = sample_index;
      seen_point.last     = last_sample;
      tracker.check_point(seen_point);
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      point_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: point_stall <= 1'b0;
        1: point_stall <= ($urandom_range(0, 99) < 35);
        2: begin
          pattern_phase = (pattern_phase + 1) % 7;
          point_stall <= (pattern_phase < 3);
        end
        default: point_stall <= ($urandom_range(0, 99) < 80);
      endcase
    end
  end

  task automatic apb_write(bit [2:0] idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Leaves tick_valid high; the caller lowers it when a gap follows.
  task automatic offer_tick(bit r);
    tick_valid <= 1'b1;
    restart    <= r;
    do @(posedge clk); while (tick_stall);
    tracker.note_tick(r);
  endtask

  task automatic send_ticks(int n, int restart_pct, int burst_max, int gap_max);
    int burst_left;
    int gap;
    bit r;
    burst_left = $urandom_range(1, burst_max);
    for (int i = 0; i < n; i++) begin
      r = ($urandom_range(0, 99) < restart_pct);
      offer_tick(r);
      burst_left--;
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, burst_max);
        if (gap_max > 0) gap = $urandom_range(1, gap_max);
      end
      if (gap > 0 || i == n - 1) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Waits until every expected point has come back, then lets the pipe empty.
  task automatic settle();
    do @(posedge clk); while (tracker.expected_points.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_value(int bits);
    bit [31:0] mask;
    bit [31:0] v;
    mask = (32'd1 << bits) - 1;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = mask;
      2: v = $urandom_range(1, 64);
      3, 4: v = $urandom & mask;
      default: v = $urandom_range(0, mask >> 4);
    endcase
    // Bits above the register width should be dropped by the block.
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << bits);
    return v;
  endfunction

  task automatic random_settings();
    apb_write(sspg_pkg::REG_RADIUS_STEP, pick_value(20));
    apb_write(sspg_pkg::REG_ANGLE_STEP, pick_value(16));
    apb_write(sspg_pkg::REG_PHASE, pick_value(16));
    apb_write(sspg_pkg::REG_IMAGE_WIDTH, pick_value(12));
    apb_write(sspg_pkg::REG_IMAGE_HEIGHT, pick_value(12));
    apb_write(sspg_pkg::REG_SAMPLE_COUNT, pick_value(16));
    settings_tried++;
  endtask

  initial begin
    int restart_pct;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    tick_valid  = 1'b0;
    restart     = 1'b0;
    point_stall = 1'b0;
    tracker     = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, with restarts both at the start and mid-sequence.
    settings_tried = 1;
    offer_tick(1'b1);
    offer_tick(1'b0);
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_tick(1'b0);
    tick_valid <= 1'b0;
    settle();

    apb_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    apb_write(REG_SPARE_HI, $urandom);
    offer_tick(1'b0);
    offer_tick(1'b0);
    tick_valid <= 1'b0;
    settle();

    // A zero count makes every beat the last; a zero-sized image has no inside.
    apb_write(sspg_pkg::REG_SAMPLE_COUNT, 0);
    apb_write(sspg_pkg::REG_IMAGE_WIDTH, 0);
    apb_write(sspg_pkg::REG_IMAGE_HEIGHT, 0);
    settings_tried++;
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_tick(1'b0);
    tick_valid <= 1'b0;
    settle();

    apb_write(sspg_pkg::REG_IMAGE_WIDTH, 12'hFFF);
    apb_write(sspg_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
    apb_write(sspg_pkg::REG_RADIUS_STEP, 20'hFFFFF);
    apb_write(sspg_pkg::REG_ANGLE_STEP, 16'hFFFF);
    apb_write(sspg_pkg::REG_PHASE, 16'hFFFF);
    apb_write(sspg_pkg::REG_SAMPLE_COUNT, 16'hFFFF);
    settings_tried++;
    offer_tick(1'b1);
    repeat (7) offer_tick(1'b0);
    tick_valid <= 1'b0;
    settle();

    // The index now sits past the new count, so the next beat must wrap.
    apb_write(sspg_pkg::REG_SAMPLE_COUNT, 5);
    settings_tried++;
    offer_tick(1'b0);
    offer_tick(1'b0);
    tick_valid <= 1'b0;
    settle();

    for (int p = 0; p < 12; p++) begin
      random_settings();
      stall_mode  <= p % 4;
      restart_pct = (p == 5) ? 50 : $urandom_range(0, 8);
      if (p == 3) begin
        // Long receiver hold while the sender keeps offering back to back.
        hold_requests <= hold_requests + 1;
        send_ticks(60, restart_pct, 60, 0);
      end else begin
        send_ticks(100, restart_pct, $urandom_range(1, 24), $urandom_range(1, 8));
      end
      settle();
    end

    // Many beats at the widest step so the coordinates run far past the saturation limits.
    stall_mode <= 0;
    apb_write(sspg_pkg::REG_RADIUS_STEP, 20'hFFFFF);
    apb_write(sspg_pkg::REG_SAMPLE_COUNT, 16'hFFFF);
    apb_write(sspg_pkg::REG_ANGLE_STEP, $urandom);
    apb_write(sspg_pkg::REG_PHASE, $urandom);
    apb_write(sspg_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 4095));
    apb_write(sspg_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 4095));
    settings_tried++;
    offer_tick(1'b1);
    send_ticks(150, 0, 50, 3);
    settle();

    $display("Sent %0d tick beats and checked %0d point beats over %0d register settings.",
             tracker.ticks, tracker.points, settings_tried);
    $display("Covered restarts, empty and largest images, zero and lowered counts, saturation.");
    if (tracker.mismatches == 0 && tracker.expected_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/sspg_pkg.sv
sv/spiral_sample_point_generator_top.sv
bench/spiral_sample_point_generator_top_tb.sv
